### rtl/uartq_pkg.sv
// Shared types and constants for the buffered serial port queues.
`timescale 1ns / 1ps

package uartq_pkg;

    // Default number of slots in each ring queue (one slot always stays empty).
    localparam int QUEUE_DEPTH = 16;

    // Width of one queued byte.
    localparam int BYTE_W = 8;

    // Event codes carried on the input channel.
    localparam logic [1:0] CMD_HOST_WRITE = 2'd0;
    localparam logic [1:0] CMD_HOST_READ  = 2'd1;
    localparam logic [1:0] CMD_TX_DONE    = 2'd2;
    localparam logic [1:0] CMD_RX_BYTE    = 2'd3;

    // Status that a ring queue reports to the control logic.
    typedef struct packed {
        logic              empty;
        logic              full;
        logic [BYTE_W-1:0] head;
    } uartq_status_t;

endpackage

### rtl/uart_buffered_tx_rx_queues.sv
// Top level of the buffered serial port: event decode, two ring queues and result register.
`timescale 1ns / 1ps

// The block takes one event per transfer on the s_ channel and returns exactly
// one result per event on the m_ channel. The queue pointers, the burst flag
// and the result are all updated at the edge that accepts the event, and the
// result stands in the m_ register from the next cycle on. A new event is
// accepted in every cycle while the result register is empty or being taken,
// so the sustained rate is one event per cycle. Each queue has DEPTH slots and
// holds at most DEPTH-1 bytes; its head byte comes from a RAM with a registered
// read that is addressed with the head pointer of the next cycle, with a bypass
// for a byte written into the head slot. The queue stores need no clearing
// after reset.

module uart_buffered_tx_rx_queues import uartq_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Event channel.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic [1:0]  s_tuser,   // [1:0] command
    // Result channel.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // [0] accepted, [8:1] read_byte, [9] read_empty,
                                   // [10] send_valid, [18:11] send_byte, [19] sending,
                                   // [23:20] zero
);

    logic              accept;
    logic [1:0]        cmd;
    logic [BYTE_W-1:0] data;

    uartq_status_t     tx_status, rx_status;
    logic              tx_push, tx_pop_try, tx_pop;
    logic              rx_push, rx_pop;
    logic [BYTE_W-1:0] tx_byte;
    logic              burst_reg, burst_next;

    logic              res_accepted;
    logic [BYTE_W-1:0] res_read_byte;
    logic              res_read_empty;
    logic              res_send_valid;
    logic [BYTE_W-1:0] res_send_byte;

    logic              m_tvalid_reg;
    logic [23:0]       m_tdata_reg;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign cmd      = s_tuser;
    assign data     = s_tdata;

    // Transmit side: push on a host write with room, then pop at once when no
    // burst runs; a transmitter-done event always tries to pop.
    assign tx_push    = accept && (cmd == CMD_HOST_WRITE) && !tx_status.full;
    assign tx_pop_try = accept && ((cmd == CMD_TX_DONE) || (tx_push && !burst_reg));
    assign tx_pop     = tx_pop_try && (!tx_status.empty || tx_push);

    // An empty queue being pushed and popped together yields the pushed byte.
    always_comb begin
        if (!tx_pop) begin
            tx_byte = '0;
        end else if (tx_status.empty) begin
            tx_byte = data;
        end else begin
            tx_byte = tx_status.head;
        end
    end

    assign res_send_valid = tx_pop_try && (tx_byte != '0);
    assign res_send_byte  = res_send_valid ? tx_byte : '0;
    assign burst_next     = tx_pop_try ? (tx_byte != '0) : burst_reg;
    assign res_accepted   = tx_push;

    // Receive side: push an arriving byte with room, pop on a host read.
    assign rx_push        = accept && (cmd == CMD_RX_BYTE) && !rx_status.full;
    assign rx_pop         = accept && (cmd == CMD_HOST_READ) && !rx_status.empty;
    assign res_read_byte  = rx_pop ? rx_status.head : '0;
    assign res_read_empty = accept && (cmd == CMD_HOST_READ) && rx_status.empty;

    uartq_queue #(
        .DEPTH (DEPTH)
    ) u_tx_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (tx_push),
        .push_data (data),
        .pop       (tx_pop),
        .status    (tx_status)
    );

    uartq_queue #(
        .DEPTH (DEPTH)
    ) u_rx_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (rx_push),
        .push_data (data),
        .pop       (rx_pop),
        .status    (rx_status)
    );

    // Burst flag and result valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            burst_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            burst_reg <= burst_next;
            if (accept) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Result payload, loaded with each accepted event.
    always_ff @(posedge aclk) begin
        if (accept) begin
            m_tdata_reg <= {4'b0000, burst_next, res_send_byte, res_send_valid,
                            res_read_empty, res_read_byte, res_accepted};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

### rtl/uartq_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
`timescale 1ns / 1ps

module uartq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port; a read of the address being
    // written returns the old contents.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/uartq_queue.sv
// Byte ring queue with one slot kept empty, holding its head byte ready each cycle.
`timescale 1ns / 1ps

module uartq_queue import uartq_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  logic [BYTE_W-1:0] push_data,
    input  logic              pop,
    output uartq_status_t     status
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);

    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  wr_ptr_inc, rd_ptr_inc;
    logic              fwd_reg, fwd_next;
    logic [BYTE_W-1:0] fwd_data_reg;
    logic [BYTE_W-1:0] ram_q;

    // Pointer advance with wrap at the last slot.
    assign wr_ptr_inc = (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + PTR_W'(1);
    assign rd_ptr_inc = (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + PTR_W'(1);

    assign wr_ptr_next = push ? wr_ptr_inc : wr_ptr_reg;
    assign rd_ptr_next = pop  ? rd_ptr_inc : rd_ptr_reg;

    // The RAM is always read at the head pointer of the next cycle. When that
    // slot is written at the same edge, the written byte is forwarded instead.
    assign fwd_next = push && (wr_ptr_reg == rd_ptr_next);

    uartq_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (push),
        .wr_addr (wr_ptr_reg),
        .wr_data (push_data),
        .rd_addr (rd_ptr_next),
        .rd_data (ram_q)
    );

    // Pointer and forwarding registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            fwd_reg    <= 1'b0;
        end else begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            fwd_reg    <= fwd_next;
        end
    end

    always_ff @(posedge aclk) begin
        fwd_data_reg <= push_data;
    end

    // Status seen by the control logic in the current cycle.
    assign status.empty = (rd_ptr_reg == wr_ptr_reg);
    assign status.full  = (wr_ptr_inc == rd_ptr_reg);
    assign status.head  = fwd_reg ? fwd_data_reg : ram_q;

endmodule

### bench/testbench.sv
// Self-checking bench for the buffered serial port queues, with a scoreboard class.
`timescale 1ns / 1ps

module testbench import uartq_pkg::*;;

    localparam int TOTAL_EVENTS = 850;
    localparam int QUIET_EVENTS = 150;
    localparam int HOLD_AT      = 200;
    localparam int LONG_HOLD    = 400;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int MAX_PRINTED  = 40;

    // One result word as it leaves the block, lowest field last.
    typedef struct packed {
        logic [3:0] pad;
        logic       sending;
        logic [7:0] send_byte;
        logic       send_valid;
        logic       read_empty;
        logic [7:0] read_byte;
        logic       accepted;
    } port_result_t;

    // Kinds of traffic segment in the random part.
    typedef enum int {
        MODE_FILL_TX,
        MODE_DRAIN_TX,
        MODE_FILL_RX,
        MODE_DRAIN_RX,
        MODE_MIXED
    } traffic_mode_t;

    // Scoreboard: predicts each event's result and checks what the block returns.
    class uart_queue_scoreboard;
        logic [7:0]   tx_slots[QUEUE_DEPTH];
        logic [7:0]   rx_slots[QUEUE_DEPTH];
        int           tx_rd, tx_wr, rx_rd, rx_wr;
        bit           burst;
        port_result_t expected_results[$];
        int           errors, checked;
        int           writes_refused, rx_dropped, empty_reads, bytes_sent, zero_stops;

        function new();
            tx_rd = 0;
            tx_wr = 0;
            rx_rd = 0;
            rx_wr = 0;
            burst = 1'b0;
            errors = 0;
            checked = 0;
            writes_refused = 0;
            rx_dropped = 0;
            empty_reads = 0;
            bytes_sent = 0;
            zero_stops = 0;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        // Pop the transmit queue and start or stop the burst on what comes out.
        function void advance_transmit(inout port_result_t res);
            logic [7:0] b;
            b = 8'h00;
            if (tx_rd != tx_wr) begin
                b = tx_slots[tx_rd];
                tx_rd = (tx_rd + 1) % QUEUE_DEPTH;
                if (b == 8'h00)
                    zero_stops++;
            end
            if (b != 8'h00) begin
                burst = 1'b1;
                res.send_valid = 1'b1;
                res.send_byte = b;
                bytes_sent++;
            end else begin
                burst = 1'b0;
            end
        endfunction

        // Note one accepted event and queue its expected result.
        function void note_event(logic [1:0] cmd, logic [7:0] data);
            port_result_t res;
            res = '0;
            case (cmd)
                CMD_HOST_WRITE: begin
                    if ((tx_wr + 1) % QUEUE_DEPTH == tx_rd) begin
                        writes_refused++;
                    end else begin
                        tx_slots[tx_wr] = data;
                        tx_wr = (tx_wr + 1) % QUEUE_DEPTH;
                        res.accepted = 1'b1;
                        if (!burst)
                            advance_transmit(res);
                    end
                end
                CMD_HOST_READ: begin
                    if (rx_rd == rx_wr) begin
                        res.read_empty = 1'b1;
                        empty_reads++;
                    end else begin
                        res.read_byte = rx_slots[rx_rd];
                        rx_rd = (rx_rd + 1) % QUEUE_DEPTH;
                    end
                end
                CMD_TX_DONE: begin
                    advance_transmit(res);
                end
                default: begin
                    if ((rx_wr + 1) % QUEUE_DEPTH == rx_rd) begin
                        rx_dropped++;
                    end else begin
                        rx_slots[rx_wr] = data;
                        rx_wr = (rx_wr + 1) % QUEUE_DEPTH;
                    end
                end
            endcase
            res.sending = burst;
            expected_results.push_back(res);
        endfunction

        task report_mismatch(string what, int want, int got);
            errors++;
            if (errors <= MAX_PRINTED)
                $display("[%0t] mismatch on result %0d: %s expected %0d, got %0d",
                         $time, checked, what, want, got);
        endtask

        task compare_field(string what, int want, int got);
            if (want != got)
                report_mismatch(what, want, got);
        endtask

        // Check one result transfer against the oldest expectation.
        task check_result(logic [23:0] raw);
            port_result_t got, want;
            got = raw;
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result, data", 0, raw);
            end else begin
                want = expected_results.pop_front();
                compare_field("accepted", want.accepted, got.accepted);
                compare_field("read_byte", want.read_byte, got.read_byte);
                compare_field("read_empty", want.read_empty, got.read_empty);
                compare_field("send_valid", want.send_valid, got.send_valid);
                compare_field("send_byte", want.send_byte, got.send_byte);
                compare_field("sending", want.sending, got.sending);
                compare_field("padding", want.pad, got.pad);
            end
            checked++;
        endtask
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;    // [7:0] data_byte
    logic [1:0]  s_tuser;    // [1:0] command
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;    // [0] accepted, [8:1] read_byte, [9] read_empty,
                             // [10] send_valid, [18:11] send_byte, [19] sending
    bit          quiet;
    int          cycle_count;
    int          sent_events;

    uart_queue_scoreboard sb = new();

    uart_buffered_tx_rx_queues uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Free-running clock.
    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Watchdog on the total run length.
    initial cycle_count = 0;
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("status: fail");
            $finish;
        end
    end

    // Result side: check each transfer, stall in random bursts or on a long hold.
    initial begin
        int stall_left;
        bit hold_done;
        stall_left = 0;
        hold_done  = 1'b0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready)
                sb.check_result(m_tdata);
            if (!hold_done && sent_events >= HOLD_AT) begin
                stall_left = LONG_HOLD;
                hold_done  = 1'b1;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(1, 16) - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Offer one event, after an optional idle burst, and wait for its transfer.
    task automatic send_event(input logic [1:0] cmd, input logic [7:0] data,
                              input bit allow_gap);
        int gap;
        if (allow_gap && !quiet && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 16);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= data;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_event(cmd, data);
        sent_events++;
    endtask

    // Stop offering until every expected result has come back.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    // Byte values weighted toward all ones, and toward zero unless a nonzero byte is asked for.
    function automatic logic [7:0] pick_byte(bit nonzero);
        int r;
        r = $urandom_range(0, 15);
        if (r == 0 && !nonzero)
            return 8'h00;
        if (r == 1)
            return 8'hFF;
        return nonzero ? 8'($urandom_range(1, 255)) : 8'($urandom_range(0, 255));
    endfunction

    // Main command of each traffic kind.
    function automatic logic [1:0] mode_command(traffic_mode_t mode);
        case (mode)
            MODE_FILL_TX:  return CMD_HOST_WRITE;
            MODE_DRAIN_TX: return CMD_TX_DONE;
            MODE_FILL_RX:  return CMD_RX_BYTE;
            MODE_DRAIN_RX: return CMD_HOST_READ;
            default:       return 2'($urandom_range(0, 3));
        endcase
    endfunction

    // Stimulus: reset, directed events, then random traffic segments.
    initial begin
        traffic_mode_t mode;
        int            seg_left, seg_index, main_pct;
        bit            seg_nonzero, seg_gaps;
        logic [1:0]    cmd;

        quiet        = 1'b0;
        sent_events  = 0;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tuser  <= CMD_HOST_WRITE;
        s_tdata  <= 8'h00;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Empty queues, zero byte while idle, a burst that a zero byte ends,
        // done while idle, and a zero byte read from a nonempty receive queue.
        send_event(CMD_HOST_READ,  8'hFF, 1'b0);
        send_event(CMD_TX_DONE,    8'hFF, 1'b0);
        send_event(CMD_HOST_WRITE, 8'h00, 1'b0);
        send_event(CMD_HOST_WRITE, 8'hFF, 1'b0);
        send_event(CMD_HOST_WRITE, 8'h80, 1'b0);
        send_event(CMD_HOST_WRITE, 8'h00, 1'b0);
        send_event(CMD_HOST_WRITE, 8'h01, 1'b0);
        send_event(CMD_TX_DONE,    8'h00, 1'b0);
        send_event(CMD_TX_DONE,    8'h00, 1'b0);
        send_event(CMD_TX_DONE,    8'h5A, 1'b0);
        send_event(CMD_TX_DONE,    8'h00, 1'b0);
        send_event(CMD_RX_BYTE,    8'h00, 1'b0);
        send_event(CMD_RX_BYTE,    8'hFF, 1'b0);
        send_event(CMD_RX_BYTE,    8'h55, 1'b0);
        send_event(CMD_HOST_READ,  8'h00, 1'b0);
        send_event(CMD_HOST_READ,  8'hAA, 1'b0);
        send_event(CMD_HOST_READ,  8'h00, 1'b0);
        send_event(CMD_HOST_READ,  8'h00, 1'b0);
        send_event(CMD_RX_BYTE,    8'hAA, 1'b0);
        send_event(CMD_HOST_WRITE, 8'h7F, 1'b0);
        send_event(CMD_HOST_READ,  8'h00, 1'b0);
        send_event(CMD_TX_DONE,    8'h00, 1'b0);
        wait_drained();

        // Random segments; the first two fill both queues past full.
        seg_left  = 0;
        seg_index = 0;
        while (sent_events < TOTAL_EVENTS) begin
            if (seg_left == 0) begin
                if (seg_index == 0) begin
                    mode = MODE_FILL_TX;
                    seg_left = 20;
                end else if (seg_index == 1) begin
                    mode = MODE_FILL_RX;
                    seg_left = 20;
                end else begin
                    mode = traffic_mode_t'($urandom_range(0, 4));
                    seg_left = $urandom_range(8, 40);
                end
                main_pct    = (seg_index < 2) ? 100 : 80;
                seg_nonzero = (seg_index < 2) || ($urandom_range(0, 3) == 0);
                seg_gaps    = ($urandom_range(0, 2) != 0);
                seg_index++;
            end
            if (sent_events == TOTAL_EVENTS - QUIET_EVENTS)
                quiet = 1'b1;
            if (sent_events == 450)
                wait_drained();
            if ($urandom_range(1, 100) <= main_pct)
                cmd = mode_command(mode);
            else
                cmd = 2'($urandom_range(0, 3));
            send_event(cmd, pick_byte(seg_nonzero), seg_gaps);
            seg_left--;
        end

        // Drain and let the block settle.
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("%0d events, %0d results checked, %0d bytes sent, %0d zero-byte stops",
                 sent_events, sb.checked, sb.bytes_sent, sb.zero_stops);
        $display("%0d writes refused on full, %0d receive bytes dropped, %0d empty reads",
                 sb.writes_refused, sb.rx_dropped, sb.empty_reads);
        if (sb.errors == 0) begin
            $display("status: pass");
        end else begin
            $display("%0d mismatches", sb.errors);
            $display("status: fail");
        end
        $finish;
    end

endmodule
